// ===== rtl/pmh_pkg.sv =====
`timescale 1ns / 1ps

package pmh_pkg;

	localparam int HASH_CHARS = 10;
	localparam int CHAR_CNT_W = $clog2(HASH_CHARS + 1);
	localparam int WORD_W     = 32;
	localparam int BYTE_W     = 8;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 6;
	localparam int BIT_CNT_W  = $clog2(BYTE_W);

	localparam logic [WORD_W-1:0] SEED_MASK = 32'h8000_8000;

	localparam logic [8*64-1:0] CHAR_TABLE =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuwvxuz0123456789+-";

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic load;
		logic round;
		logic seed_en;
		logic shift_out;
		logic clear;
	} pmh_cmd_t;

	typedef struct packed {
		logic seed_zero;
	} pmh_status_t;

	// The first character of the string sits in the top byte of the vector.
	function automatic logic [CHAR_W-1:0] char_lookup(input logic [DIGIT_W-1:0] idx);
		return CHAR_TABLE[{~idx, 3'b000} +: CHAR_W];
	endfunction

endpackage

// ===== rtl/pmh_byte_if.sv =====
`timescale 1ns / 1ps

interface pmh_byte_if import pmh_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] pass_byte;
	logic              final_byte;

	modport source (output valid, output pass_byte, output final_byte, input ready);
	modport sink (input valid, input pass_byte, input final_byte, output ready);
endinterface

// ===== rtl/pmh_char_if.sv =====
`timescale 1ns / 1ps

interface pmh_char_if import pmh_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] hash_char;
	logic              final_char;

	modport source (output valid, output hash_char, output final_char, input ready);
	modport sink (input valid, input hash_char, input final_char, output ready);
endinterface

// ===== rtl/pmh_datapath.sv =====
`timescale 1ns / 1ps

module pmh_datapath import pmh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  pmh_cmd_t          cmd,
	input  logic [BYTE_W-1:0] pass_byte,
	output pmh_status_t       status,
	output logic [CHAR_W-1:0] hash_char
);

	word_t a1_q, a2_q, a4_q, b1_q, b2_q, b4_q;
	logic [BYTE_W-1:0] byte_q;

	word_t a1, a2x, b2x, a3, b3, a3n, b3n, a2n, b2n, a4n, b4n, a2f, b2f, b1n, a1n, b1;

	always_comb begin
		a1  = a1_q | ((cmd.seed_en && byte_q[0]) ? SEED_MASK : '0);
		b1  = b1_q | ((cmd.seed_en && byte_q[0]) ? SEED_MASK : '0);
		a2x = a2_q ^ a1;
		b2x = b2_q ^ b1;
		a3  = a2x ^ a1;
		b3  = b2x ^ b1;
		b3n = {a3[1:0], b3[WORD_W-1:2]};
		a3n = a3 >> 2;
		a2n = a3n ^ a2x;
		b2n = b3n ^ b2x;
		a4n = ~a4_q ^ a2n;
		b4n = (word_t'(0) - b4_q) ^ b2n;
		a2f = a4n ^ ~a2n;
		b2f = b4n ^ (word_t'(0) - b2n);
		b1n = {a1[0], b1[WORD_W-1:1]};
		a1n = a1 >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a1_q <= '0;
			a2_q <= '0;
			a4_q <= '0;
			b1_q <= '0;
			b2_q <= '0;
			b4_q <= '0;
		end else if (cmd.clear) begin
			a1_q <= '0;
			a2_q <= '0;
			a4_q <= '0;
			b1_q <= '0;
			b2_q <= '0;
			b4_q <= '0;
		end else if (cmd.round) begin
			a1_q <= a1n;
			a2_q <= a2f;
			a4_q <= a4n;
			b1_q <= b1n;
			b2_q <= b2f;
			b4_q <= b4n;
		end else if (cmd.shift_out) begin
			// The result pair moves down by one character.
			b4_q <= {a4_q[DIGIT_W-1:0], b4_q[WORD_W-1:DIGIT_W]};
			a4_q <= a4_q >> DIGIT_W;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= pass_byte;
		end else if (cmd.seed_en) begin
			byte_q <= byte_q >> 1;
		end
	end

	assign status.seed_zero = (a1_q == '0) && (b1_q == '0);
	assign hash_char        = char_lookup(b4_q[DIGIT_W-1:0]);

endmodule

// ===== rtl/pmh_ctrl.sv =====
`timescale 1ns / 1ps

module pmh_ctrl import pmh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_final,
	output logic        in_ready,
	output logic        out_valid,
	output logic        out_final,
	input  logic        out_ready,
	input  pmh_status_t status,
	output pmh_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MIX   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	localparam logic [BIT_CNT_W-1:0]  LAST_BIT  = BIT_CNT_W'(BYTE_W - 1);
	localparam logic [CHAR_CNT_W-1:0] LAST_CHAR = CHAR_CNT_W'(HASH_CHARS - 1);

	logic [1:0]            state_q, state_d;
	logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
	logic [CHAR_CNT_W-1:0] char_cnt_q, char_cnt_d;
	logic                  final_q, final_d;

	always_comb begin
		state_d    = state_q;
		bit_cnt_d  = bit_cnt_q;
		char_cnt_d = char_cnt_q;
		final_d    = final_q;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		out_final  = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_MIX: begin
				cmd.round   = 1'b1;
				cmd.seed_en = 1'b1;
				if (bit_cnt_q == LAST_BIT) begin
					if (final_q) begin
						state_d = ST_DRAIN;
					end else begin
						in_ready = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					bit_cnt_d = bit_cnt_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (status.seed_zero) begin
					char_cnt_d = '0;
					state_d    = ST_EMIT;
				end else begin
					cmd.round = 1'b1;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				out_final = (char_cnt_q == LAST_CHAR);
				if (out_ready) begin
					if (out_final) begin
						cmd.clear = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						cmd.shift_out = 1'b1;
						char_cnt_d    = char_cnt_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (in_valid && in_ready) begin
			cmd.load  = 1'b1;
			final_d   = in_final;
			bit_cnt_d = '0;
			state_d   = ST_MIX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bit_cnt_q  <= '0;
			char_cnt_q <= '0;
			final_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			bit_cnt_q  <= bit_cnt_d;
			char_cnt_q <= char_cnt_d;
			final_q    <= final_d;
		end
	end

endmodule

// ===== rtl/password_mix_hash_top.sv =====
`timescale 1ns / 1ps

// Password bytes enter one transaction at a time on pass_in, each marked with
// final_byte on the last one. Every byte runs eight mixing rounds, one round
// per cycle for each bit, and the next byte is accepted in the cycle of the
// last round. After the final byte the round unit keeps running until both
// seed words are zero, and once a check finds them zero, ten hash characters
// leave on hash_out, one transaction per cycle while the sink is ready, the
// tenth carrying final_char. The mixing state is then cleared and the next
// password may start.

module password_mix_hash_top import pmh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	pmh_byte_if.sink          pass_in,
	pmh_char_if.source        hash_out
);

	pmh_cmd_t    cmd;
	pmh_status_t status;

	pmh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pass_in.valid),
		.in_final  (pass_in.final_byte),
		.in_ready  (pass_in.ready),
		.out_valid (hash_out.valid),
		.out_final (hash_out.final_char),
		.out_ready (hash_out.ready),
		.status    (status),
		.cmd       (cmd)
	);

	pmh_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.pass_byte (pass_in.pass_byte),
		.status    (status),
		.hash_char (hash_out.hash_char)
	);

endmodule
